// ----- rtl/vgu_pkg.sv -----
// Shared types and constants for the 3-component vector geometry unit.
`timescale 1ns / 1ps

package vgu_pkg;

    // Operation codes carried in the mode field of a request.
    typedef enum logic [3:0] {
        MODE_ADD       = 4'd0,
        MODE_SUB       = 4'd1,
        MODE_MUL       = 4'd2,
        MODE_DIV       = 4'd3,
        MODE_CROSS     = 4'd4,
        MODE_DOT       = 4'd5,
        MODE_LENGTH    = 4'd6,
        MODE_NORMALIZE = 4'd7,
        MODE_EQUAL     = 4'd8
    } mode_t;

    typedef logic signed [31:0] word_t;

    localparam word_t WORD_MAX = 32'sh7fffffff;
    localparam word_t WORD_MIN = 32'sh80000000;

    // Register stages of the front end and of the square-root pipeline.
    localparam int FRONT_STAGES = 3;
    localparam int SQRT_STAGES  = 32;

    typedef struct packed {
        logic [3:0] mode;
        word_t      a_x;
        word_t      a_y;
        word_t      a_z;
        word_t      b_x;
        word_t      b_y;
        word_t      b_z;
    } request_t;

    typedef struct packed {
        word_t res_x;
        word_t res_y;
        word_t res_z;
        word_t res_scalar;
        logic  is_equal;
        logic  overflow;
        logic  div_zero;
    } result_t;

    // Payload that rides along the square-root and divider pipelines.
    typedef struct packed {
        logic [3:0]  mode;
        word_t [2:0] a;
        word_t [2:0] b;
        result_t     rsp;
    } side_t;

endpackage

// ----- rtl/vgu_front.sv -----
// Front end: products, sums and saturation for the single-pass operations.
`timescale 1ns / 1ps

module vgu_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  vgu_pkg::request_t request,
    output logic             out_valid,
    output vgu_pkg::side_t   side,
    output logic [63:0]      sumsq
);
    import vgu_pkg::*;

    logic              v1_reg, v2_reg, v3_reg;
    logic [3:0]        mode1_reg, mode2_reg;
    word_t             a1_reg [3];
    word_t             b1_reg [3];
    word_t             a2_reg [3];
    word_t             b2_reg [3];
    logic signed [63:0] p1_reg [6];
    logic signed [63:0] p1_next [6];
    logic signed [65:0] t2_reg [3];
    logic signed [65:0] t2_next [3];
    logic [63:0]       sq2_reg;
    logic              eq2_reg;
    side_t             side3_reg, side3_next;
    logic [63:0]       sq3_reg;

    word_t av [3];
    word_t bv [3];
    word_t ml [6];
    word_t mr [6];
    logic  is_cross, is_sq;
    logic signed [65:0] sum3;

    // Saturate a wide value to a word; the top bit flags saturation.
    function automatic logic [32:0] sat_word(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return {1'b1, 32'h7fffffff};
        end
        else if (v < -66'sd2147483648) begin
            return {1'b1, 32'h80000000};
        end
        return {1'b0, v[31:0]};
    endfunction

    assign av[0] = request.a_x;
    assign av[1] = request.a_y;
    assign av[2] = request.a_z;
    assign bv[0] = request.b_x;
    assign bv[1] = request.b_y;
    assign bv[2] = request.b_z;

    assign is_cross = (request.mode == MODE_CROSS);
    assign is_sq    = (request.mode == MODE_LENGTH) || (request.mode == MODE_NORMALIZE);

    // Stage 1: six multipliers. Even ones are shared by the elementwise,
    // dot and square modes; odd ones only serve the cross product.
    always_comb
    begin
        ml[0] = is_cross ? av[1] : av[0];
        mr[0] = is_cross ? bv[2] : (is_sq ? av[0] : bv[0]);
        ml[1] = av[2];
        mr[1] = bv[1];
        ml[2] = is_cross ? av[2] : av[1];
        mr[2] = is_cross ? bv[0] : (is_sq ? av[1] : bv[1]);
        ml[3] = av[0];
        mr[3] = bv[2];
        ml[4] = is_cross ? av[0] : av[2];
        mr[4] = is_cross ? bv[1] : (is_sq ? av[2] : bv[2]);
        ml[5] = av[1];
        mr[5] = bv[0];
        for (int k = 0; k < 6; k++)
        begin
            p1_next[k] = ml[k] * mr[k];
        end
    end

    // Stage 2: exact sums and differences at full precision.
    assign sum3 = 66'(p1_reg[0]) + 66'(p1_reg[2]) + 66'(p1_reg[4]);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            t2_next[i] = '0;
            case (mode1_reg)
                MODE_ADD:   t2_next[i] = 66'(a1_reg[i]) + 66'(b1_reg[i]);
                MODE_SUB:   t2_next[i] = 66'(a1_reg[i]) - 66'(b1_reg[i]);
                MODE_MUL:   t2_next[i] = 66'(p1_reg[2 * i]);
                MODE_CROSS: t2_next[i] = 66'(p1_reg[2 * i]) - 66'(p1_reg[2 * i + 1]);
                MODE_DOT:   t2_next[i] = (i == 0) ? sum3 : '0;
                default:    t2_next[i] = '0;
            endcase
        end
    end

    // Stage 3: scale the products back and saturate the results.
    always_comb
    begin
        logic [32:0] sr [3];
        logic        scaled;
        scaled = (mode2_reg == MODE_MUL) || (mode2_reg == MODE_CROSS) ||
                 (mode2_reg == MODE_DOT);
        for (int i = 0; i < 3; i++)
        begin
            sr[i] = sat_word(scaled ? (t2_reg[i] >>> FRAC_BITS) : t2_reg[i]);
        end
        side3_next.mode = mode2_reg;
        for (int i = 0; i < 3; i++)
        begin
            side3_next.a[i] = a2_reg[i];
            side3_next.b[i] = b2_reg[i];
        end
        side3_next.rsp = '0;
        case (mode2_reg) inside
            MODE_ADD, MODE_SUB, MODE_MUL, MODE_CROSS:
            begin
                side3_next.rsp.res_x    = sr[0][31:0];
                side3_next.rsp.res_y    = sr[1][31:0];
                side3_next.rsp.res_z    = sr[2][31:0];
                side3_next.rsp.overflow = sr[0][32] | sr[1][32] | sr[2][32];
            end
            MODE_DOT:
            begin
                side3_next.rsp.res_scalar = sr[0][31:0];
                side3_next.rsp.overflow   = sr[0][32];
            end
            MODE_EQUAL:
            begin
                side3_next.rsp.is_equal = eq2_reg;
            end
            default:
            begin
                side3_next.rsp = '0;
            end
        endcase
    end

    // Valid bits of the three stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Stage payload registers.
    always_ff @(posedge clk)
    begin
        mode1_reg <= request.mode;
        for (int i = 0; i < 3; i++)
        begin
            a1_reg[i] <= av[i];
            b1_reg[i] <= bv[i];
            a2_reg[i] <= a1_reg[i];
            b2_reg[i] <= b1_reg[i];
            t2_reg[i] <= t2_next[i];
        end
        for (int k = 0; k < 6; k++)
        begin
            p1_reg[k] <= p1_next[k];
        end
        mode2_reg <= mode1_reg;
        sq2_reg   <= sum3[63:0];
        eq2_reg   <= (a1_reg[0] == b1_reg[0]) && (a1_reg[1] == b1_reg[1]) &&
                     (a1_reg[2] == b1_reg[2]);
        side3_reg <= side3_next;
        sq3_reg   <= sq2_reg;
    end

    assign out_valid = v3_reg;
    assign side      = side3_reg;
    assign sumsq     = sq3_reg;

endmodule

// ----- rtl/vgu_sqrt.sv -----
// Pipelined integer square root of the sum of squares, one result bit per stage.
`timescale 1ns / 1ps

module vgu_sqrt (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  vgu_pkg::side_t in_side,
    input  logic [63:0]    in_sumsq,
    output logic           out_valid,
    output vgu_pkg::side_t out_side,
    output logic [31:0]    root
);
    import vgu_pkg::*;

    logic [SQRT_STAGES-1:0] v_reg;
    side_t       side_reg [SQRT_STAGES];
    logic [63:0] s_reg    [SQRT_STAGES];
    logic [63:0] s_next   [SQRT_STAGES];
    logic [63:0] r_reg    [SQRT_STAGES];
    logic [63:0] r_next   [SQRT_STAGES];
    logic [63:0] s_in     [SQRT_STAGES];
    logic [63:0] r_in     [SQRT_STAGES];

    // Each stage tries one root bit against the running remainder.
    always_comb
    begin
        logic [63:0] bitv;
        logic [63:0] trial;
        s_in[0] = in_sumsq;
        r_in[0] = '0;
        for (int k = 1; k < SQRT_STAGES; k++)
        begin
            s_in[k] = s_reg[k - 1];
            r_in[k] = r_reg[k - 1];
        end
        for (int k = 0; k < SQRT_STAGES; k++)
        begin
            bitv  = 64'(1) << (62 - 2 * k);
            trial = r_in[k] + bitv;
            if (s_in[k] >= trial)
            begin
                s_next[k] = s_in[k] - trial;
                r_next[k] = (r_in[k] >> 1) + bitv;
            end
            else
            begin
                s_next[k] = s_in[k];
                r_next[k] = r_in[k] >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[SQRT_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= in_side;
        for (int k = 1; k < SQRT_STAGES; k++)
        begin
            side_reg[k] <= side_reg[k - 1];
        end
        s_reg <= s_next;
        r_reg <= r_next;
    end

    assign out_valid = v_reg[SQRT_STAGES-1];
    assign out_side  = side_reg[SQRT_STAGES-1];
    assign root      = r_reg[SQRT_STAGES-1][31:0];

endmodule

// ----- rtl/vgu_div.sv -----
// Three-lane pipelined restoring divider and the final result register.
`timescale 1ns / 1ps

module vgu_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  vgu_pkg::side_t   in_side,
    input  logic [31:0]      root,
    output logic             done,
    output vgu_pkg::result_t result
);
    import vgu_pkg::*;

    // Quotient width: a 32-bit magnitude shifted up by the fraction bits.
    localparam int NW = 32 + FRAC_BITS;

    logic [NW-1:0] v_reg;
    side_t         side_reg [NW];
    logic [31:0]   rem_reg  [NW][3];
    logic [31:0]   rem_next [NW][3];
    logic [NW-1:0] num_reg  [NW][3];
    logic [NW-1:0] num_next [NW][3];
    logic [31:0]   den_reg  [NW][3];
    logic [31:0]   rem_in   [NW][3];
    logic [NW-1:0] num_in   [NW][3];
    logic [31:0]   den_in   [NW][3];
    side_t         entry_side;
    logic          done_reg;
    result_t       result_reg, result_next;

    // Entry: operand magnitudes, divisor choice and the length result.
    // Later stages take their operands from the previous stage registers.
    always_comb
    begin
        logic [31:0] abs_a;
        logic [31:0] abs_b;
        logic [31:0] len;
        len = (root == '0) ? (32'(1) << FRAC_BITS) : root;
        for (int i = 0; i < 3; i++)
        begin
            abs_a = in_side.a[i][31] ? 32'(-in_side.a[i]) : 32'(in_side.a[i]);
            abs_b = in_side.b[i][31] ? 32'(-in_side.b[i]) : 32'(in_side.b[i]);
            rem_in[0][i] = '0;
            num_in[0][i] = NW'(abs_a) << FRAC_BITS;
            den_in[0][i] = (in_side.mode == MODE_NORMALIZE) ? len : abs_b;
        end
        for (int j = 1; j < NW; j++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                rem_in[j][i] = rem_reg[j - 1][i];
                num_in[j][i] = num_reg[j - 1][i];
                den_in[j][i] = den_reg[j - 1][i];
            end
        end
        entry_side = in_side;
        if (in_side.mode == MODE_LENGTH)
        begin
            entry_side.rsp.res_scalar = root[31] ? WORD_MAX : root;
            entry_side.rsp.overflow   = root[31];
        end
    end

    // One quotient bit per stage and lane; quotient bits shift into num.
    always_comb
    begin
        logic [32:0] rs;
        logic [33:0] diff;
        for (int j = 0; j < NW; j++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                rs   = {rem_in[j][i], num_in[j][i][NW-1]};
                diff = {1'b0, rs} - {2'b00, den_in[j][i]};
                rem_next[j][i] = diff[33] ? rs[31:0] : diff[31:0];
                num_next[j][i] = {num_in[j][i][NW-2:0], ~diff[33]};
            end
        end
    end

    // Final: sign, saturation and division-by-zero handling.
    always_comb
    begin
        side_t         sd;
        logic [NW-1:0] q;
        logic          neg;
        logic          a_zero;
        logic          b_zero;
        word_t         val [3];
        logic [2:0]    ovf;
        logic [2:0]    dz;
        sd = side_reg[NW-1];
        for (int i = 0; i < 3; i++)
        begin
            q      = num_reg[NW-1][i];
            a_zero = (sd.a[i] == '0);
            b_zero = (sd.b[i] == '0);
            neg    = sd.a[i][31] ^ ((sd.mode == MODE_DIV) && sd.b[i][31]);
            ovf[i] = 1'b0;
            dz[i]  = 1'b0;
            if ((sd.mode == MODE_DIV) && b_zero)
            begin
                dz[i]  = 1'b1;
                val[i] = a_zero ? '0 : (sd.a[i][31] ? WORD_MIN : WORD_MAX);
            end
            else if (!neg)
            begin
                ovf[i] = (q > NW'(64'h7fffffff));
                val[i] = ovf[i] ? WORD_MAX : q[31:0];
            end
            else
            begin
                ovf[i] = (q > NW'(64'h80000000));
                val[i] = ovf[i] ? WORD_MIN : 32'(-q[31:0]);
            end
        end
        result_next = sd.rsp;
        if ((sd.mode == MODE_DIV) || (sd.mode == MODE_NORMALIZE))
        begin
            result_next.res_x    = val[0];
            result_next.res_y    = val[1];
            result_next.res_z    = val[2];
            result_next.overflow = sd.rsp.overflow | (|ovf);
            result_next.div_zero = |dz;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg    <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            v_reg    <= {v_reg[NW-2:0], in_valid};
            done_reg <= v_reg[NW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= entry_side;
        for (int j = 1; j < NW; j++)
        begin
            side_reg[j] <= side_reg[j - 1];
        end
        rem_reg    <= rem_next;
        num_reg    <= num_next;
        den_reg    <= den_in;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- rtl/vector3_geometry_unit.sv -----
// Throughput: one request per cycle; busy stays low and results are never held.
// The pipeline runs through 3 front stages, 32 square-root stages, 32 + FRAC_BITS
// divider stages and the output register; every mode takes the same path.
// Reset: rst_n clears all valid bits at once; no clearing pass is needed.
// Top level of the 3-component vector geometry unit.
`timescale 1ns / 1ps

module vector3_geometry_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  vgu_pkg::request_t request,
    output logic              done,
    output vgu_pkg::result_t  result
);
    import vgu_pkg::*;

    logic        front_valid;
    side_t       front_side;
    logic [63:0] front_sumsq;
    logic        sqrt_valid;
    side_t       sqrt_side;
    logic [31:0] sqrt_root;

    // The pipeline never stalls, so a request is taken in every cycle.
    assign busy = 1'b0;

    vgu_front #(
        .FRAC_BITS(FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start && !busy),
        .request  (request),
        .out_valid(front_valid),
        .side     (front_side),
        .sumsq    (front_sumsq)
    );

    vgu_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (front_valid),
        .in_side  (front_side),
        .in_sumsq (front_sumsq),
        .out_valid(sqrt_valid),
        .out_side (sqrt_side),
        .root     (sqrt_root)
    );

    vgu_div #(
        .FRAC_BITS(FRAC_BITS)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(sqrt_valid),
        .in_side (sqrt_side),
        .root    (sqrt_root),
        .done    (done),
        .result  (result)
    );

endmodule

// ----- rtl/vgu_checker.sv -----
// Port-level checks on the vector geometry unit, bound to the top level.
`timescale 1ns / 1ps

module vgu_checker #(
    parameter int FRAC_BITS = 16
) (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input vgu_pkg::request_t request,
    input logic              done,
    input vgu_pkg::result_t  result
);
    import vgu_pkg::*;

    localparam int LAT = FRONT_STAGES + SQRT_STAGES + 32 + FRAC_BITS + 1;
    localparam int WW  = $clog2(LAT + 1);

    logic [WW-1:0] warm_reg, warm_next;

    // Cycles since reset, held once the pipeline has filled.
    assign warm_next = (warm_reg == WW'(LAT)) ? warm_reg : warm_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warm_reg <= '0;
        end
        else
        begin
            warm_reg <= warm_next;
        end
    end

    // Every request yields exactly one result, and no result appears without a request.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (warm_reg == WW'(LAT)) |-> (done == $past(start && !busy, LAT)))
        else $error("result strobe does not match the request of LAT cycles ago");

    // The unit accepts requests in every cycle.
    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy)
        else $error("busy raised while a request was offered");

    // An equality result carries no vector, scalar or divide flag.
    a_equal_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.is_equal) |-> ((result.res_x == '0) && (result.res_y == '0) &&
        (result.res_z == '0) && (result.res_scalar == '0) && !result.div_zero))
        else $error("equality result has stray fields");

    // A divide-by-zero result carries no scalar and no equality.
    a_divzero_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.div_zero) |-> ((result.res_scalar == '0) && !result.is_equal))
        else $error("divide-by-zero result has stray fields");

endmodule

bind vector3_geometry_unit vgu_checker #(.FRAC_BITS(FRAC_BITS)) u_vgu_checker (.*);
